/* rtl/lpr_pkg.sv */
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared constants and chain types for the LRU page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

   localparam int FRAMES_DEF    = 4;
   localparam int PAGE_BITS_DEF = 16;
   localparam int FAULT_BITS    = 32;

   // ripples from frame 0 upward: a lower frame already matched / is empty
   typedef struct packed {
      logic hit;
      logic empty;
   } lpr_scan_type;

   // result of the scan, sent back to every frame cell
   typedef struct packed {
      logic found;
      logic have_empty;
   } lpr_ctl_type;

endpackage : lpr_pkg

`default_nettype wire

/* rtl/lpr_cell.sv */
// ----------------------------------------------------------------------------
// lpr_cell
// One frame of the table: page tag, valid bit and recency rank, with its
// link of the priority scan chain and of the pick chain.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_cell
   import lpr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF,
   parameter int CELL_IDX  = 0
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         upd,
   input  wire logic [PAGE_BITS-1:0]         page_i,
   input  wire lpr_scan_type                 scan_i,
   output      lpr_scan_type                 scan_o,
   input  wire lpr_ctl_type                  ctl_i,
   input  wire logic [$clog2(FRAMES)-1:0]    old_rank_i,
   input  wire logic [$clog2(FRAMES)-1:0]    pick_rank_i,
   output      logic [$clog2(FRAMES)-1:0]    pick_rank_o,
   input  wire logic [PAGE_BITS-1:0]         pick_page_i,
   output      logic [PAGE_BITS-1:0]         pick_page_o,
   input  wire logic [$clog2(FRAMES)-1:0]    pick_idx_i,
   output      logic [$clog2(FRAMES)-1:0]    pick_idx_o,
   output      logic                         sel_o
);

   localparam int IDX_W = $clog2(FRAMES);

   logic [PAGE_BITS-1:0] page_ff;
   logic                 valid_ff;
   logic                 valid_in;
   logic [IDX_W-1:0]     rank_ff;
   logic [IDX_W-1:0]     rank_in;
   logic                 eq;
   logic                 mine_hit;
   logic                 mine_empty;
   logic                 is_lru;
   logic                 sel;

   assign eq         = valid_ff && (page_ff == page_i);
   assign mine_hit   = eq && !scan_i.hit;
   assign mine_empty = !valid_ff && !scan_i.empty;
   assign is_lru     = (rank_ff == IDX_W'(FRAMES - 1));

   assign scan_o.hit   = scan_i.hit | eq;
   assign scan_o.empty = scan_i.empty | !valid_ff;

   always_comb begin
      if (ctl_i.found) begin
         sel = mine_hit;
      end else if (ctl_i.have_empty) begin
         sel = mine_empty;
      end else begin
         sel = is_lru;
      end
   end

   assign sel_o       = sel;
   assign pick_rank_o = pick_rank_i | (sel ? rank_ff : '0);
   assign pick_page_o = pick_page_i | (sel ? page_ff : '0);
   assign pick_idx_o  = pick_idx_i | (sel ? IDX_W'(CELL_IDX) : '0);

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (upd) begin
         if (sel) begin
            valid_in = 1'b1;
            rank_in  = '0;
         end else if (rank_ff < old_rank_i) begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= IDX_W'(CELL_IDX);
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   // tag loads only on a fill or a replacement
   always_ff @(posedge clock) begin
      if (upd && sel && !ctl_i.found) begin
         page_ff <= page_i;
      end
   end

endmodule : lpr_cell

`default_nettype wire

/* rtl/lru_page_replacement.sv */
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative frame table with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   A page number transfers in on req_valid/req_ready. One result transfers
//   out on rsp_valid/rsp_ready per request: hit flag, frame now holding the
//   page, evicted page (if a full table forced a replacement) and the
//   saturating fault total.
//   A request is first held in the input register, then looked up and
//   committed, and its result is registered for the output channel.
//   Throughput: one request per cycle unless a result stalls. The frames
//   form a row of cells; a request is matched against all of them through
//   the scan chain, and the chosen frame is picked through a second chain.
//   Reset: all frames empty, recency rank equal to frame index, fault total
//   zero, both channels idle.
//   Stall: while a result waits on rsp_ready, one more request is held in
//   the input register; req_ready drops until the result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement
   import lpr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [PAGE_BITS-1:0]        req_page,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic                        rsp_hit,
   output      logic [$clog2(FRAMES)-1:0]   rsp_frame,
   output      logic                        rsp_evicted_valid,
   output      logic [PAGE_BITS-1:0]        rsp_evicted_page,
   output      logic [FAULT_BITS-1:0]       rsp_fault_count
);

   localparam int IDX_W = $clog2(FRAMES);

   logic [PAGE_BITS-1:0]  page_ff;
   logic                  pend_ff;
   logic                  pend_in;
   logic                  proc;
   logic                  req_xfer;

   logic [FAULT_BITS-1:0] fault_ff;
   logic [FAULT_BITS-1:0] fault_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_hit_ff;
   logic [IDX_W-1:0]      rsp_frame_ff;
   logic                  rsp_evicted_valid_ff;
   logic [PAGE_BITS-1:0]  rsp_evicted_page_ff;
   logic [FAULT_BITS-1:0] rsp_fault_count_ff;

   lpr_scan_type          scan   [FRAMES+1];
   logic [IDX_W-1:0]      p_rank [FRAMES+1];
   logic [PAGE_BITS-1:0]  p_page [FRAMES+1];
   logic [IDX_W-1:0]      p_idx  [FRAMES+1];
   logic [FRAMES-1:0]     sel_vec;
   lpr_ctl_type           ctl;
   logic                  evict;

   assign proc      = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !pend_ff || proc;
   assign req_xfer  = req_valid && req_ready;

   assign scan[0].hit   = 1'b0;
   assign scan[0].empty = 1'b0;
   assign p_rank[0]     = '0;
   assign p_page[0]     = '0;
   assign p_idx[0]      = '0;

   assign ctl.found      = scan[FRAMES].hit;
   assign ctl.have_empty = scan[FRAMES].empty;
   assign evict          = !ctl.found && !ctl.have_empty;

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      lpr_cell #(
         .FRAMES    (FRAMES),
         .PAGE_BITS (PAGE_BITS),
         .CELL_IDX  (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .upd         (proc),
         .page_i      (page_ff),
         .scan_i      (scan[i]),
         .scan_o      (scan[i+1]),
         .ctl_i       (ctl),
         .old_rank_i  (p_rank[FRAMES]),
         .pick_rank_i (p_rank[i]),
         .pick_rank_o (p_rank[i+1]),
         .pick_page_i (p_page[i]),
         .pick_page_o (p_page[i+1]),
         .pick_idx_i  (p_idx[i]),
         .pick_idx_o  (p_idx[i+1]),
         .sel_o       (sel_vec[i])
      );
   end

   always_comb begin
      fault_in = fault_ff;
      if (proc && !ctl.found && (fault_ff != {FAULT_BITS{1'b1}})) begin
         fault_in = fault_ff + 1'b1;
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (req_xfer) begin
         pend_in = 1'b1;
      end else if (proc) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (proc) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fault_ff     <= '0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         fault_ff     <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         page_ff <= req_page;
      end
      if (proc) begin
         rsp_hit_ff           <= ctl.found;
         rsp_frame_ff         <= p_idx[FRAMES];
         rsp_evicted_valid_ff <= evict;
         rsp_evicted_page_ff  <= evict ? p_page[FRAMES] : '0;
         rsp_fault_count_ff   <= fault_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame         = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_fault_count   = rsp_fault_count_ff;

   // exactly one frame is chosen for every committed request
   a_one_sel: assert property (@(posedge clock) disable iff (reset)
      proc |-> $onehot(sel_vec))
      else $error("frame selection not one-hot");

   // a hit never replaces a page
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_evicted_valid_ff))
      else $error("hit reported with eviction");

   // hits leave the fault total alone
   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      proc && ctl.found |=> fault_ff == $past(fault_ff))
      else $error("fault count moved on a hit");

   // fault total never goes down
   a_fault_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> fault_ff >= $past(fault_ff))
      else $error("fault count decreased");

   // a request taken on the input is always held for lookup
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> pend_ff)
      else $error("accepted request lost");

endmodule : lru_page_replacement

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for lru_page_replacement: page requests go in through a bursty
// driver, results come back through a stalling receiver, and each result is
// checked field by field against an LRU frame table kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import lpr_pkg::*;

   localparam int FRAMES       = FRAMES_DEF;
   localparam int PAGE_BITS    = PAGE_BITS_DEF;
   localparam int FRAME_W      = $clog2(FRAMES);
   localparam int RANDOM_ITEMS = 1250;
   localparam int HOLD_CYCLES  = 240;
   localparam int LIMIT        = 200000;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic                  hit;
      logic [FRAME_W-1:0]    frame;
      logic                  evicted_valid;
      logic [PAGE_BITS-1:0]  evicted_page;
      logic [FAULT_BITS-1:0] fault_count;
   } page_result_type;

   typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [PAGE_BITS-1:0]  req_page;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_hit;
   logic [FRAME_W-1:0]    rsp_frame;
   logic                  rsp_evicted_valid;
   logic [PAGE_BITS-1:0]  rsp_evicted_page;
   logic [FAULT_BITS-1:0] rsp_fault_count;

   // testbench copy of the frame table
   logic [PAGE_BITS-1:0]  resident_page [FRAMES];
   logic                  resident_valid [FRAMES];
   logic [FRAME_W-1:0]    use_rank [FRAMES];
   logic [FAULT_BITS-1:0] fault_total;

   logic [PAGE_BITS-1:0]  pending_pages [$];
   page_result_type       results_due [$];

   logic        req_fire;
   int          burst_left;
   int          gap_left;
   rx_mode_type rx_mode;
   int          rx_phase_left;
   int          rx_tick;
   logic        rx_open;
   logic        hold_off;

   int requests_taken;
   int results_taken;
   int hits_seen;
   int evictions_seen;
   int mismatches;
   int cycle_count;

   lru_page_replacement #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page          (req_page),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame         (rsp_frame),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Look up one page in the table, update recency and fault total, and
   // queue the result the block should return for it.
   task automatic lru_lookup(input logic [PAGE_BITS-1:0] page);
      page_result_type    res;
      int                 i;
      int                 slot;
      bit                 found;
      bit                 have_empty;
      logic [FRAME_W-1:0] old_rank;
      res        = '0;
      slot       = 0;
      found      = 0;
      have_empty = 0;
      for (i = 0; i < FRAMES; i++) begin
         if (!found && resident_valid[i] && resident_page[i] == page) begin
            found = 1;
            slot  = i;
         end
      end
      if (!found) begin
         for (i = 0; i < FRAMES; i++) begin
            if (!have_empty && !resident_valid[i]) begin
               have_empty = 1;
               slot       = i;
            end
         end
         // table full: the oldest frame gives way
         if (!have_empty) begin
            for (i = 0; i < FRAMES; i++) begin
               if (use_rank[i] == FRAME_W'(FRAMES - 1)) slot = i;
            end
            res.evicted_valid = 1'b1;
            res.evicted_page  = resident_page[slot];
         end
         resident_page[slot]  = page;
         resident_valid[slot] = 1'b1;
         if (fault_total != '1) fault_total = fault_total + 1'b1;
      end
      old_rank = use_rank[slot];
      for (i = 0; i < FRAMES; i++) begin
         if (use_rank[i] < old_rank) use_rank[i] = use_rank[i] + 1'b1;
      end
      use_rank[slot]  = '0;
      res.hit         = found;
      res.frame       = FRAME_W'(slot);
      res.fault_count = fault_total;
      results_due.push_back(res);
   endtask

   // driver: bursts of requests separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_pages.size() != 0) begin
            req_valid <= 1'b1;
            req_page  <= pending_pages.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 32);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern picks a new random mode after each phase of random length
   always @(negedge clock) begin
      rx_tick <= rx_tick + 1;
      if (rx_phase_left == 0) begin
         rx_mode       <= rx_mode_type'($urandom_range(0, 3));
         rx_phase_left <= $urandom_range(16, 96);
      end else begin
         rx_phase_left <= rx_phase_left - 1;
      end
      case (rx_mode)
         RX_STEADY: rx_open = 1'b1;
         RX_COIN:   rx_open = 1'($urandom_range(0, 1));
         RX_SPARSE: rx_open = ($urandom_range(0, 3) == 0);
         default:   rx_open = (rx_tick[2:0] != 3'b111) && (rx_tick[4:3] != 2'b00);
      endcase
      rsp_ready <= !reset && !hold_off && rx_open;
   end

   // long receiver hold-off so the block fills up and back-pressures requests
   initial begin
      hold_off = 1'b0;
      while (requests_taken < 300) @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   // monitor: predict on request transfers, check on result transfers
   always @(posedge clock) begin
      page_result_type want;
      page_result_type got;
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_taken++;
            got = '{rsp_hit, rsp_frame, rsp_evicted_valid, rsp_evicted_page,
                    rsp_fault_count};
            if (results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result: hit=%0b frame=%0d ev=%0b evpage=%h faults=%0d",
                           got.hit, got.frame, got.evicted_valid, got.evicted_page,
                           got.fault_count);
            end else begin
               want = results_due.pop_front();
               if (got.hit !== want.hit || got.frame !== want.frame ||
                   got.evicted_valid !== want.evicted_valid ||
                   got.evicted_page !== want.evicted_page ||
                   got.fault_count !== want.fault_count) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("result %0d mismatch:", results_taken);
                     $display("   exp hit=%0b frame=%0d ev=%0b evpage=%h faults=%0d",
                              want.hit, want.frame, want.evicted_valid,
                              want.evicted_page, want.fault_count);
                     $display("   act hit=%0b frame=%0d ev=%0b evpage=%h faults=%0d",
                              got.hit, got.frame, got.evicted_valid, got.evicted_page,
                              got.fault_count);
                  end
               end
               if (want.hit) hits_seen++;
               if (want.evicted_valid) evictions_seen++;
            end
         end
         if (req_valid && req_ready) begin
            requests_taken++;
            lru_lookup(req_page);
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      logic [PAGE_BITS-1:0] pool [8];
      int pool_n;
      int run_len;
      int k;
      int total;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_page       = '0;
      rsp_ready      = 1'b0;
      req_fire       = 1'b0;
      burst_left     = 4;
      gap_left       = 0;
      rx_mode        = RX_STEADY;
      rx_phase_left  = 40;
      rx_tick        = 0;
      rx_open        = 1'b1;
      requests_taken = 0;
      results_taken  = 0;
      hits_seen      = 0;
      evictions_seen = 0;
      mismatches     = 0;
      fault_total    = '0;
      for (k = 0; k < FRAMES; k++) begin
         resident_page[k]  = '0;
         resident_valid[k] = 1'b0;
         use_rank[k]       = FRAME_W'(k);
      end

      // directed: fill from empty, hits that reshuffle recency, evictions,
      // pages at the extremes and neighbors that differ in one bit
      pending_pages = '{16'h0000, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA,
                        16'hFFFF, 16'h1234, 16'h0000, 16'h5555, 16'hEDCB,
                        16'h8000, 16'h0001, 16'h8000, 16'h0001, 16'h1234,
                        16'h7FFF, 16'hFFFE, 16'h7FFF, 16'h0000, 16'hFFFF,
                        16'h7FFF, 16'h8000};
      total = pending_pages.size() + RANDOM_ITEMS;

      // random: short runs over a small working set so hits and evictions
      // both come often, with a sprinkle of stray pages
      while (pending_pages.size() < total) begin
         pool_n = $urandom_range(2, 7);
         for (k = 0; k < pool_n; k++) begin
            if (k > 0 && $urandom_range(0, 3) == 0)
               pool[k] = pool[0] ^ (16'h1 << $urandom_range(0, PAGE_BITS - 1));
            else
               pool[k] = PAGE_BITS'($urandom_range(0, 16'hFFFF));
         end
         run_len = $urandom_range(8, 48);
         for (k = 0; k < run_len; k++) begin
            if ($urandom_range(0, 9) == 0)
               pending_pages.push_back(PAGE_BITS'($urandom_range(0, 16'hFFFF)));
            else
               pending_pages.push_back(pool[$urandom_range(0, pool_n - 1)]);
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_pages.size() != 0 || req_valid) @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d requests, %0d results: %0d hits, %0d evictions, %0d faults",
               requests_taken, results_taken, hits_seen, evictions_seen, fault_total);
      $display("bursty requests, mixed receiver stalls, one %0d-cycle hold-off; %0d mismatches",
               HOLD_CYCLES, mismatches);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
